// ===== rtl/fyu_pkg.sv =====
// ----------------------------------------------------------------------------
// fyu_pkg
// Shared types, constants and saturating Q8.24 arithmetic for the Yee grid
// update engine.
// ----------------------------------------------------------------------------
package fyu_pkg;

  // Grid geometry: each extent is a power of two, cell address is {x, y, z}
  localparam int GRID_X     = 16;
  localparam int GRID_Y     = 16;
  localparam int GRID_Z     = 16;
  localparam int XB         = $clog2(GRID_X);
  localparam int YB         = $clog2(GRID_Y);
  localparam int ZB         = $clog2(GRID_Z);
  localparam int CELL_BITS  = XB + YB + ZB;
  localparam int NUM_CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int VW         = 32;
  localparam int FRAC_BITS  = 24;
  localparam int NUM_FIELDS = 6;
  localparam int NUM_COEFS  = 9;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [2:0]           fsel_t;
  typedef logic [3:0]           csel_t;
  typedef logic [1:0]           axis_t;

  typedef struct packed {
    logic [XB-1:0] x;
    logic [YB-1:0] y;
    logic [ZB-1:0] z;
  } cell_t;

  typedef enum logic [2:0] {
    ACT_WR_FIELD = 3'd0,
    ACT_WR_COEF  = 3'd1,
    ACT_UPD_H    = 3'd2,
    ACT_UPD_E    = 3'd3,
    ACT_RD_FIELD = 3'd4
  } action_t;

  localparam fsel_t F_EX = 3'd0;
  localparam fsel_t F_EY = 3'd1;
  localparam fsel_t F_EZ = 3'd2;
  localparam fsel_t F_HX = 3'd3;
  localparam fsel_t F_HY = 3'd4;
  localparam fsel_t F_HZ = 3'd5;

  localparam csel_t C_HXS = 4'd0;
  localparam csel_t C_HXC = 4'd1;
  localparam csel_t C_HYS = 4'd2;
  localparam csel_t C_HYC = 4'd3;
  localparam csel_t C_HZS = 4'd4;
  localparam csel_t C_HZC = 4'd5;
  localparam csel_t C_EXC = 4'd6;
  localparam csel_t C_EYC = 4'd7;
  localparam csel_t C_EZC = 4'd8;

  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  localparam logic [1:0] COMP_LAST = 2'd2;

  // Request into the arithmetic pipeline
  typedef struct packed {
    logic valid;
    logic is_e;
    val_t a1;
    val_t a0;
    val_t b1;
    val_t b0;
    val_t own;
    val_t cs;
    val_t cc;
  } alu_req_t;

  typedef struct packed {
    logic valid;
    val_t value;
  } alu_rsp_t;

  function automatic val_t add_sat(val_t a, val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    return s[VW-1:0];
  endfunction

  function automatic val_t sub_sat(val_t a, val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    return s[VW-1:0];
  endfunction

  // Floor shift of a full product by the fraction bits, then clamp
  function automatic val_t q_sat(logic signed [2*VW-1:0] p);
    logic signed [2*VW-1:0] t;
    t = p >>> FRAC_BITS;
    if (&t[2*VW-1:VW-1] || ~|t[2*VW-1:VW-1]) return t[VW-1:0];
    return t[2*VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  // Field updated by component comp of the sweep
  function automatic fsel_t comp_own(logic is_e, logic [1:0] comp);
    case (comp)
      2'd0:    return is_e ? F_EX : F_HX;
      2'd1:    return is_e ? F_EY : F_HY;
      default: return is_e ? F_EZ : F_HZ;
    endcase
  endfunction

  // First term of the curl
  function automatic fsel_t comp_a(logic is_e, logic [1:0] comp);
    case (comp)
      2'd0:    return is_e ? F_HZ : F_EY;
      2'd1:    return is_e ? F_HX : F_EZ;
      default: return is_e ? F_HY : F_EX;
    endcase
  endfunction

  // Second term of the curl
  function automatic fsel_t comp_b(logic is_e, logic [1:0] comp);
    case (comp)
      2'd0:    return is_e ? F_HY : F_EZ;
      2'd1:    return is_e ? F_HZ : F_EX;
      default: return is_e ? F_HX : F_EY;
    endcase
  endfunction

  function automatic axis_t axis_a(logic is_e, logic [1:0] comp);
    case (comp)
      2'd0:    return is_e ? AX_Y : AX_Z;
      2'd1:    return is_e ? AX_Z : AX_X;
      default: return is_e ? AX_X : AX_Y;
    endcase
  endfunction

  function automatic axis_t axis_b(logic is_e, logic [1:0] comp);
    case (comp)
      2'd0:    return is_e ? AX_Z : AX_Y;
      2'd1:    return is_e ? AX_X : AX_Z;
      default: return is_e ? AX_Y : AX_X;
    endcase
  endfunction

  function automatic csel_t coef_self(logic [1:0] comp);
    case (comp)
      2'd0:    return C_HXS;
      2'd1:    return C_HYS;
      default: return C_HZS;
    endcase
  endfunction

  function automatic csel_t coef_curl(logic is_e, logic [1:0] comp);
    case (comp)
      2'd0:    return is_e ? C_EXC : C_HXC;
      2'd1:    return is_e ? C_EYC : C_HYC;
      default: return is_e ? C_EZC : C_HZC;
    endcase
  endfunction

  // Neighbor one step up (H sweep) or down (E sweep) along an axis
  function automatic cell_t nb_cell(cell_t c, axis_t ax, logic is_e);
    cell_t r;
    r = c;
    case (ax)
      AX_X:    r.x = is_e ? c.x - XB'(1) : c.x + XB'(1);
      AX_Y:    r.y = is_e ? c.y - YB'(1) : c.y + YB'(1);
      default: r.z = is_e ? c.z - ZB'(1) : c.z + ZB'(1);
    endcase
    return r;
  endfunction

  // Whether a component is updated at a cell
  function automatic logic comp_active(logic is_e, logic [1:0] comp, cell_t c);
    logic lx, ly, lz, zx, zy, zz;
    lx = (c.x == XB'(GRID_X - 1));
    ly = (c.y == YB'(GRID_Y - 1));
    lz = (c.z == ZB'(GRID_Z - 1));
    zx = (c.x == '0);
    zy = (c.y == '0);
    zz = (c.z == '0);
    case (comp)
      2'd0:    return is_e ? (!lx && !ly && !lz && !zy && !zz) : (!ly && !lz);
      2'd1:    return is_e ? (!lx && !ly && !lz && !zx && !zz) : (!lx && !lz);
      default: return is_e ? (!lx && !ly && !lz && !zx && !zy) : (!lx && !ly);
    endcase
  endfunction

endpackage

// ===== rtl/fyu_if.sv =====
// ----------------------------------------------------------------------------
// fyu_in_if / fyu_out_if
// Valid/ready channels for items into the engine and results out of it.
// ----------------------------------------------------------------------------
interface fyu_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [3:0]          array_sel;
  logic [3:0]          cell_x;
  logic [3:0]          cell_y;
  logic [3:0]          cell_z;
  logic signed [31:0]  write_value;

  modport source (output valid, action, array_sel, cell_x, cell_y, cell_z, write_value,
                  input ready);
  modport sink   (input valid, action, array_sel, cell_x, cell_y, cell_z, write_value,
                  output ready);
endinterface

interface fyu_out_if;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic signed [31:0]  read_value;

  modport source (output valid, result_kind, read_value, input ready);
  modport sink   (input valid, result_kind, read_value, output ready);
endinterface

// ===== rtl/fdtd_3d_yee_update.sv =====
// ----------------------------------------------------------------------------
// fdtd_3d_yee_update
// Yee grid store with field/coefficient access and whole-grid H and E sweeps.
// ----------------------------------------------------------------------------
// After reset the block zeroes every cell of the six field memories and
// takes no item until that pass ends. Field and coefficient writes are made
// on the transfer itself; a field read returns its value through the memory
// read register and then the result register, and no item is taken while it
// is pending. An H or E update item walks all 4096 cells; each active field
// component of a cell is read from the field memories, which have one read
// port each, in two issues, passed through a five-stage arithmetic pipeline
// and written back, while a skipped component is passed over. A done result
// is given when the sweep ends.
// ----------------------------------------------------------------------------
module fdtd_3d_yee_update import fyu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fyu_in_if.sink    in_ch,
  fyu_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_ISSUE1 = 6'b000100,
    S_ISSUE2 = 6'b001000,
    S_CAPT   = 6'b010000,
    S_WAIT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  cell_t      n_r, n_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic       is_e_r, is_e_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  fsel_t      rd_sel_r, rd_sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  val_t       out_value_r, out_value_nxt;
  val_t       a1_r, b1_r, own_r, cs_r, cc_r;

  logic [CELL_BITS-1:0] fld_raddr [NUM_FIELDS];
  val_t                 fld_rdata [NUM_FIELDS];
  logic [NUM_FIELDS-1:0] fld_we;
  logic [CELL_BITS-1:0] fld_waddr;
  val_t                 fld_wdata;
  val_t                 coef_rdata [NUM_COEFS];
  logic [NUM_COEFS-1:0] coef_we;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic  in_xfer, out_xfer, active, comp_done;
  cell_t in_cell, nb_a, nb_b;
  fsel_t sel_own, sel_a, sel_b;
  csel_t sel_cs, sel_cc;
  action_t in_act;

  assign in_act  = action_t'(in_ch.action);
  assign in_cell = '{x: in_ch.cell_x, y: in_ch.cell_y, z: in_ch.cell_z};
  assign in_ch.ready = (state_r == S_IDLE) && !rd_pend_r && (!out_valid_r || out_ch.ready);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  // Component routing for the current cell
  assign sel_own = comp_own(is_e_r, comp_r);
  assign sel_a   = comp_a(is_e_r, comp_r);
  assign sel_b   = comp_b(is_e_r, comp_r);
  assign sel_cs  = coef_self(comp_r);
  assign sel_cc  = coef_curl(is_e_r, comp_r);
  assign nb_a    = nb_cell(n_r, axis_a(is_e_r, comp_r), is_e_r);
  assign nb_b    = nb_cell(n_r, axis_b(is_e_r, comp_r), is_e_r);
  assign active  = comp_active(is_e_r, comp_r, n_r);

  // Field memory read addresses: first read takes the upper curl term
  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      if (state_r == S_IDLE) begin
        fld_raddr[f] = in_cell;
      end else if (fsel_t'(f) == sel_a) begin
        fld_raddr[f] = ((state_r == S_ISSUE1) != is_e_r) ? nb_a : n_r;
      end else if (fsel_t'(f) == sel_b) begin
        fld_raddr[f] = ((state_r == S_ISSUE1) != is_e_r) ? nb_b : n_r;
      end else begin
        fld_raddr[f] = n_r;
      end
    end
  end

  // Field memory write port: clear pass, item write or write-back
  always_comb begin
    fld_we    = '0;
    fld_waddr = in_cell;
    fld_wdata = in_ch.write_value;
    if (state_r == S_CLEAR) begin
      fld_we    = '1;
      fld_waddr = n_r;
      fld_wdata = '0;
    end else if (state_r == S_WAIT) begin
      fld_waddr = n_r;
      fld_wdata = alu_rsp.value;
      fld_we[sel_own] = alu_rsp.valid;
    end else if (in_xfer && in_act == ACT_WR_FIELD && in_ch.array_sel < 4'(NUM_FIELDS)) begin
      fld_we[in_ch.array_sel[2:0]] = 1'b1;
    end
  end

  always_comb begin
    coef_we = '0;
    if (in_xfer && in_act == ACT_WR_COEF && in_ch.array_sel < 4'(NUM_COEFS)) begin
      coef_we[in_ch.array_sel] = 1'b1;
    end
  end

  for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_fld
    fyu_ram #(.WIDTH(VW), .DEPTH(NUM_CELLS)) u_ram (
      .clk   (clk),
      .we    (fld_we[g]),
      .waddr (fld_waddr),
      .wdata (fld_wdata),
      .raddr (fld_raddr[g]),
      .rdata (fld_rdata[g])
    );
  end

  for (genvar g = 0; g < NUM_COEFS; g++) begin : g_coef
    fyu_ram #(.WIDTH(VW), .DEPTH(NUM_CELLS)) u_ram (
      .clk   (clk),
      .we    (coef_we[g]),
      .waddr (in_cell),
      .wdata (in_ch.write_value),
      .raddr (n_r),
      .rdata (coef_rdata[g])
    );
  end

  // Arithmetic request once the lower curl terms arrive
  always_comb begin
    alu_req.valid = (state_r == S_CAPT);
    alu_req.is_e  = is_e_r;
    alu_req.a1    = a1_r;
    alu_req.a0    = fld_rdata[sel_a];
    alu_req.b1    = b1_r;
    alu_req.b0    = fld_rdata[sel_b];
    alu_req.own   = own_r;
    alu_req.cs    = cs_r;
    alu_req.cc    = cc_r;
  end

  fyu_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign comp_done = ((state_r == S_ISSUE1) && !active) ||
                     ((state_r == S_WAIT) && alu_rsp.valid);

  // Sequencer and result register
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    comp_nxt      = comp_r;
    is_e_nxt      = is_e_r;
    rd_pend_nxt   = 1'b0;
    rd_sel_nxt    = rd_sel_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;

    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = 1'b0;
      out_value_nxt = (rd_sel_r < fsel_t'(NUM_FIELDS)) ? fld_rdata[rd_sel_r] : '0;
    end

    case (state_r)
      S_CLEAR: begin
        n_nxt = n_r + CELL_BITS'(1);
        if (&n_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_act)
            ACT_UPD_H, ACT_UPD_E: begin
              state_nxt = S_ISSUE1;
              is_e_nxt  = (in_act == ACT_UPD_E);
              n_nxt     = '0;
              comp_nxt  = '0;
            end
            ACT_RD_FIELD: begin
              rd_pend_nxt = 1'b1;
              rd_sel_nxt  = (in_ch.array_sel < 4'(NUM_FIELDS)) ? in_ch.array_sel[2:0]
                                                               : fsel_t'(NUM_FIELDS);
            end
            default: ;
          endcase
        end
      end
      S_ISSUE1: begin
        if (active) begin
          state_nxt = S_ISSUE2;
        end
      end
      S_ISSUE2: state_nxt = S_CAPT;
      S_CAPT:   state_nxt = S_WAIT;
      S_WAIT:   ;
      default:  state_nxt = S_IDLE;
    endcase

    // Advance to the next component, cell, or finish the sweep
    if (comp_done) begin
      state_nxt = S_ISSUE1;
      if (comp_r == COMP_LAST) begin
        comp_nxt = '0;
        n_nxt    = n_r + CELL_BITS'(1);
        if (&n_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_value_nxt = '0;
        end
      end else begin
        comp_nxt = comp_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      n_r         <= '0;
      comp_r      <= '0;
      is_e_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      comp_r      <= comp_nxt;
      is_e_r      <= is_e_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload and captured operands
  always_ff @(posedge clk) begin
    rd_sel_r    <= rd_sel_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    if (state_r == S_ISSUE2) begin
      a1_r  <= fld_rdata[sel_a];
      b1_r  <= fld_rdata[sel_b];
      own_r <= fld_rdata[sel_own];
      cs_r  <= coef_rdata[sel_cs];
      cc_r  <= coef_rdata[sel_cc];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.read_value  = out_value_r;

endmodule

// ===== rtl/fyu_ram.sv =====
// ----------------------------------------------------------------------------
// fyu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fyu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fyu_alu.sv =====
// ----------------------------------------------------------------------------
// fyu_alu
// Five-stage pipeline for one cell component: curl, products, floor shift
// with saturation, and the final saturating sum.
// ----------------------------------------------------------------------------
module fyu_alu import fyu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [4:0] vld_r;
  logic       is_e1_r, is_e2_r, is_e3_r, is_e4_r;
  val_t       da_r, db_r, own1_r, cs1_r, cc1_r;
  val_t       curl_r, own2_r, cs2_r, cc2_r;
  logic signed [2*VW-1:0] ps_r, pc_r;
  val_t       own3_r, own4_r, ms_r, mc_r;
  val_t       res_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], req.valid};
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    da_r    <= sub_sat(req.a1, req.a0);
    db_r    <= sub_sat(req.b1, req.b0);
    own1_r  <= req.own;
    cs1_r   <= req.cs;
    cc1_r   <= req.cc;
    is_e1_r <= req.is_e;

    curl_r  <= sub_sat(da_r, db_r);
    own2_r  <= own1_r;
    cs2_r   <= cs1_r;
    cc2_r   <= cc1_r;
    is_e2_r <= is_e1_r;

    ps_r    <= cs2_r * own2_r;
    pc_r    <= cc2_r * curl_r;
    own3_r  <= own2_r;
    is_e3_r <= is_e2_r;

    ms_r    <= q_sat(ps_r);
    mc_r    <= q_sat(pc_r);
    own4_r  <= own3_r;
    is_e4_r <= is_e3_r;

    res_r   <= add_sat(is_e4_r ? own4_r : ms_r, mc_r);
  end

  assign rsp.valid = vld_r[4];
  assign rsp.value = res_r;

endmodule
